// ----- hdl/blr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blr_pkg: shared types and constants for the line rasterizer
// Coordinate and error widths, frame size, octant and phase codes, and the
// octant classifier used on line load.
// ----------------------------------------------------------------------------
package blr_pkg;

	localparam int COORD_BITS   = 12;
	localparam int COLOR_BITS   = 8;
	localparam int ERR_BITS     = 16;
	localparam int FRAME_WIDTH  = 1920;
	localparam int FRAME_HEIGHT = 1080;

	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic signed [COORD_BITS:0]   delta_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic [COLOR_BITS-1:0]        color_t;

	// octant minus one, as kept in the state register
	typedef enum logic [2:0] {
		OCT1 = 3'd0,
		OCT2 = 3'd1,
		OCT3 = 3'd2,
		OCT4 = 3'd3,
		OCT5 = 3'd4,
		OCT6 = 3'd5,
		OCT7 = 3'd6,
		OCT8 = 3'd7
	} octant_t;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_WALK   = 2'd2
	} phase_t;

	// exact integer slope test on dx = end - start, dy = end - start
	function automatic octant_t classify(delta_t dx, delta_t dy);
		delta_t  ndx;
		octant_t oct;
		ndx = -dx;
		if (dx == '0) begin
			if (dy == '0)
				oct = OCT8;
			else if (dy > 0)
				oct = OCT2;
			else
				oct = OCT7;
		end else if (dx > 0) begin
			if (dy >= 0 && dy <= dx)
				oct = OCT1;
			else if (dy > dx)
				oct = OCT2;
			else if (dy < ndx)
				oct = OCT7;
			else
				oct = OCT8;
		end else begin
			if (dy >= dx && dy <= 0)
				oct = OCT5;
			else if (dy < dx)
				oct = OCT6;
			else if (dy > ndx)
				oct = OCT3;
			else
				oct = OCT4;
		end
		return oct;
	endfunction

endpackage

// ----- hdl/bresenham_line_rasterizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core: eight-octant line engine, one pixel a step
// Load words set up a line; step words each return one pixel word.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): mode 0 loads endpoints and colour and
//    returns nothing; mode 1 asks for the next pixel and returns one word.
//  - Output channel (out_valid/out_ready): one word per step, in order: first
//    endpoint, second endpoint, then the interior walk. last_pixel marks the
//    final pixel; a step with no line in progress returns line_active = 0.
//  - Pixels off the 1920x1080 frame come out with inside_frame = 0.
//  - Timing: a step word's pixel is in the output register in the cycle after
//    it is accepted. One word is accepted every cycle unless the receiver stalls;
//    each step is a single add and compare on the decision variable, done
//    between the state registers and the output register.
//  - When the receiver stalls, the pending pixel holds in the output register
//    and in_ready drops until it is taken (it stays high in the cycle the
//    pixel is taken, so the next word enters without a gap).
//  - A load while a line is in progress drops that line.
//  - Reset clears out_valid and leaves the engine idle.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_core
	import blr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic [COLOR_BITS-1:0] colour_red,
	input  logic [COLOR_BITS-1:0] colour_green,
	input  logic [COLOR_BITS-1:0] colour_blue,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0] pixel_red,
	output logic [COLOR_BITS-1:0] pixel_green,
	output logic [COLOR_BITS-1:0] pixel_blue,
	output logic                  inside_frame,
	output logic                  line_active,
	output logic                  last_pixel
);

	// engine state
	logic    busy_q;
	phase_t  phase_q;
	octant_t oct_q;
	coord_t  major_q, minor_q, bound_q;
	err_t    err_q, up_q, right_q;
	coord_t  sx_q, sy_q, ex_q, ey_q;
	color_t  red_q, green_q, blue_q;

	// output register
	logic    out_valid_q;
	coord_t  px_q, py_q;
	color_t  pr_q, pg_q, pb_q;
	logic    inside_q, active_q, last_q;

	logic    acc;

	// load path
	delta_t  dx, dy, dmaj, dmin;
	octant_t ld_oct;
	coord_t  ld_start, ld_bound, ld_minor;
	err_t    ld_err, ld_up, ld_right;

	// step path
	logic    rising, strict_fall, major_y, dec_minor;
	logic    has_more, is_last, err_pos;
	err_t    walk_err;
	coord_t  walk_minor;

	logic    busy_d;
	phase_t  phase_d;
	coord_t  major_d, minor_d;
	err_t    err_d;
	coord_t  st_x, st_y;
	logic    st_last, st_active, st_inside;

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;

	// ---------------- load setup ----------------
	always_comb begin
		dx     = delta_t'({1'b0, end_x}) - delta_t'({1'b0, start_x});
		dy     = delta_t'({1'b0, end_y}) - delta_t'({1'b0, start_y});
		ld_oct = classify(dx, dy);
		unique case (ld_oct)
			OCT1: begin
				ld_start = start_x + coord_t'(1); ld_bound = end_x; ld_minor = start_y;
				dmaj = dx;  dmin = dy;
			end
			OCT2: begin
				ld_start = start_y + coord_t'(1); ld_bound = end_y; ld_minor = start_x;
				dmaj = dy;  dmin = dx;
			end
			OCT3: begin
				ld_start = end_y - coord_t'(1); ld_bound = start_y; ld_minor = end_x;
				dmaj = dy;  dmin = -dx;
			end
			OCT4: begin
				ld_start = start_x - coord_t'(1); ld_bound = end_x; ld_minor = start_y;
				dmaj = -dx; dmin = dy;
			end
			OCT5: begin
				ld_start = end_x + coord_t'(1); ld_bound = start_x; ld_minor = end_y;
				dmaj = -dx; dmin = -dy;
			end
			OCT6: begin
				ld_start = start_y - coord_t'(1); ld_bound = end_y; ld_minor = start_x;
				dmaj = -dy; dmin = -dx;
			end
			OCT7: begin
				ld_start = start_y - coord_t'(1); ld_bound = end_y; ld_minor = start_x;
				dmaj = -dy; dmin = dx;
			end
			default: begin
				ld_start = start_x + coord_t'(1); ld_bound = end_x; ld_minor = start_y;
				dmaj = dx;  dmin = -dy;
			end
		endcase
		// single point: no interior
		if (dmaj == '0)
			ld_start = ld_bound;
		ld_err   = (err_t'(dmin) <<< 1) - err_t'(dmaj);
		ld_up    = (err_t'(dmin) - err_t'(dmaj)) <<< 1;
		ld_right = err_t'(dmin) <<< 1;
	end

	// ---------------- step ----------------
	always_comb begin
		rising      = (oct_q == OCT1) || (oct_q == OCT2) || (oct_q == OCT5) || (oct_q == OCT8);
		strict_fall = (oct_q == OCT3) || (oct_q == OCT4);
		major_y     = (oct_q == OCT2) || (oct_q == OCT3) || (oct_q == OCT6) || (oct_q == OCT7);
		dec_minor   = (oct_q == OCT6) || (oct_q == OCT8);

		if (rising) begin
			has_more = major_q < bound_q;
			is_last  = ({1'b0, major_q} + 1'b1) >= {1'b0, bound_q};
		end else if (strict_fall) begin
			has_more = major_q > bound_q;
			is_last  = {1'b0, major_q} <= ({1'b0, bound_q} + 1'b1);
		end else begin
			// octants 6 and 7 also emit the pixel at the bound
			has_more = major_q >= bound_q;
			is_last  = major_q == bound_q;
		end

		err_pos = err_q > 0;
		if (err_pos) begin
			walk_err   = err_q + up_q;
			walk_minor = dec_minor ? minor_q - coord_t'(1) : minor_q + coord_t'(1);
		end else begin
			walk_err   = err_q + right_q;
			walk_minor = minor_q;
		end

		busy_d    = busy_q;
		phase_d   = phase_q;
		major_d   = major_q;
		minor_d   = minor_q;
		err_d     = err_q;
		st_x      = '0;
		st_y      = '0;
		st_last   = 1'b0;
		st_active = 1'b0;

		if (busy_q) begin
			st_active = 1'b1;
			unique case (phase_q)
				PH_FIRST: begin
					st_x    = sx_q;
					st_y    = sy_q;
					phase_d = PH_SECOND;
				end
				PH_SECOND: begin
					st_x    = ex_q;
					st_y    = ey_q;
					st_last = !has_more;
					phase_d = PH_WALK;
				end
				PH_WALK: begin
					err_d   = walk_err;
					minor_d = walk_minor;
					st_x    = major_y ? walk_minor : major_q;
					st_y    = major_y ? major_q : walk_minor;
					st_last = is_last;
					if (!is_last)
						major_d = rising ? major_q + coord_t'(1) : major_q - coord_t'(1);
				end
				default: begin
					phase_d = PH_FIRST;
				end
			endcase
			if (st_last)
				busy_d = 1'b0;
		end

		st_inside = st_active &&
			({1'b0, st_x} < (COORD_BITS+1)'(FRAME_WIDTH)) &&
			({1'b0, st_y} < (COORD_BITS+1)'(FRAME_HEIGHT));
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_FIRST;
			oct_q   <= OCT1;
		end else if (acc) begin
			if (!mode) begin
				busy_q  <= 1'b1;
				phase_q <= PH_FIRST;
				oct_q   <= ld_oct;
			end else begin
				busy_q  <= busy_d;
				phase_q <= phase_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (!mode) begin
				major_q <= ld_start;
				minor_q <= ld_minor;
				bound_q <= ld_bound;
				err_q   <= ld_err;
				up_q    <= ld_up;
				right_q <= ld_right;
				sx_q    <= start_x;
				sy_q    <= start_y;
				ex_q    <= end_x;
				ey_q    <= end_y;
				red_q   <= colour_red;
				green_q <= colour_green;
				blue_q  <= colour_blue;
			end else begin
				major_q <= major_d;
				minor_q <= minor_d;
				err_q   <= err_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (in_ready)
			out_valid_q <= in_valid && mode;
	end

	always_ff @(posedge clk) begin
		if (acc && mode) begin
			px_q     <= st_x;
			py_q     <= st_y;
			pr_q     <= busy_q ? red_q : '0;
			pg_q     <= busy_q ? green_q : '0;
			pb_q     <= busy_q ? blue_q : '0;
			inside_q <= st_inside;
			active_q <= st_active;
			last_q   <= st_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign pixel_red    = pr_q;
	assign pixel_green  = pg_q;
	assign pixel_blue   = pb_q;
	assign inside_frame = inside_q;
	assign line_active  = active_q;
	assign last_pixel   = last_q;

	// ---------------- checks ----------------
	// decision variable stays within +/-8190 during the walk
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && phase_q == PH_WALK) |-> (err_q >= -err_t'(8190) && err_q <= err_t'(8190)))
		else $error("decision variable out of range");

	// a load always restarts the line at the first endpoint
	a_load_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !mode) |=> (busy_q && phase_q == PH_FIRST))
		else $error("load did not restart the line");

	// a step with no line in progress gives an inactive word
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode && !busy_q) |=> (out_valid_q && !active_q && !inside_q && !last_q))
		else $error("idle step produced a line pixel");

	// the final pixel ends the line
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode && st_last) |=> !busy_q)
		else $error("line still busy after last pixel");

	// the last pixel word is always an active one
	a_last_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> active_q)
		else $error("last pixel flagged on an inactive word");

endmodule
